@@ src/ird_pkg.sv @@
package ird_pkg;

   localparam int LEVELS    = 16;
   localparam int MIN_LEVEL = 0;
   localparam int LEVEL_W   = 4;
   localparam int DUTY_W    = 9;
   localparam int CNT_W     = 8;
   localparam int KEYS      = 8;
   localparam int KEY_W     = 63;
   localparam int CSR_IDX_W = 3;

   localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LEVELS - 1);
   localparam logic [LEVEL_W-1:0] BOT_LEVEL = LEVEL_W'(MIN_LEVEL);
   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

   // frame event kinds
   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_FRAME  = 2'd1;
   localparam logic [1:0] FUNC_REPEAT = 2'd2;

   // key slots within key_codes
   localparam logic [2:0] KEY_UP   = 3'd0;
   localparam logic [2:0] KEY_DOWN = 3'd1;
   localparam logic [2:0] KEY_OFF  = 3'd2;
   localparam logic [2:0] KEY_ON   = 3'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_CODES          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_DELAY       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_LENGTH       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_TIMEOUT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAVE_DELAY         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SAVE_ENABLE        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_BRIGHTNESS = 3'd7;

   localparam logic [LEVEL_W-1:0] RESET_BRIGHTNESS = 4'd15;

   function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
      return (v > TOP_LEVEL) ? TOP_LEVEL : v;
   endfunction

   function automatic logic [7:0] gamma_value(input logic [LEVEL_W-1:0] lvl);
      logic [7:0] g;
      unique case (lvl)
         4'd0:    g = 8'd0;
         4'd1:    g = 8'd4;
         4'd2:    g = 8'd6;
         4'd3:    g = 8'd9;
         4'd4:    g = 8'd12;
         4'd5:    g = 8'd16;
         4'd6:    g = 8'd21;
         4'd7:    g = 8'd28;
         4'd8:    g = 8'd37;
         4'd9:    g = 8'd49;
         4'd10:   g = 8'd64;
         4'd11:   g = 8'd84;
         4'd12:   g = 8'd111;
         4'd13:   g = 8'd146;
         4'd14:   g = 8'd192;
         default: g = 8'd255;
      endcase
      return g;
   endfunction

   // preset keys occupy slots four to seven
   function automatic logic [LEVEL_W-1:0] preset_level(input logic [1:0] sel);
      logic [LEVEL_W-1:0] p;
      unique case (sel)
         2'd0:    p = 4'd1;
         2'd1:    p = 4'd6;
         2'd2:    p = 4'd12;
         default: p = 4'd15;
      endcase
      return clamp_level(p);
   endfunction

endpackage

@@ src/ir_remote_dimmer_controller.sv @@
// channel | ports                                   | direction
// req     | req_valid/req_ready, func, frame_bits   | in, one control tick per transfer
// rsp     | rsp_valid/rsp_ready, duty, lit, save    | out, one result per tick
// csr     | csr_valid/csr_ready, index, data        | in, register writes
// a tick is decoded and the state updated in the cycle of its transfer; the
// result is registered for the next cycle; one tick per clock unless rsp stalls.
// req_ready stays high while the output register is empty or being drained,
// so a stalled rsp side stalls req after one result. csr is always ready.
// synchronous reset sets rsp_valid, configuration and state, but not the result payload.
module ir_remote_dimmer_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_func,
   input  logic [31:0]                       req_frame_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ird_pkg::DUTY_W-1:0]        rsp_pwm_duty,
   output logic                              rsp_indicator_lit,
   output logic                              rsp_save_request,
   output logic [ird_pkg::LEVEL_W-1:0]       rsp_save_value,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ird_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ird_pkg::KEY_W-1:0]         csr_data
);
   import ird_pkg::*;

   // configuration
   logic [7:0]         dev_addr_ff;
   logic [KEY_W-1:0]   key_codes_ff;
   logic [CNT_W-1:0]   rep_delay_ff;
   logic [CNT_W-1:0]   blink_len_ff;
   logic [CNT_W-1:0]   rep_timeout_ff;
   logic [CNT_W-1:0]   save_delay_ff;
   logic               save_en_ff;

   // state
   logic [LEVEL_W-1:0] bright_ff, bright_in;
   logic               on_ff, on_in;
   logic [DUTY_W-1:0]  duty_ff, duty_in;
   logic [7:0]         last_cmd_ff, last_cmd_in;
   logic [CNT_W-1:0]   rep_cnt_ff, rep_cnt_in;
   logic [CNT_W-1:0]   idle_cnt_ff, idle_cnt_in;
   logic [CNT_W-1:0]   blink_cnt_ff, blink_cnt_in;
   logic [CNT_W-1:0]   save_cnt_ff, save_cnt_in;
   logic [LEVEL_W-1:0] stored_ff, stored_in;

   // result register
   logic               rsp_valid_ff;
   logic [DUTY_W-1:0]  rsp_duty_ff;
   logic               rsp_lit_ff, rsp_lit_in;
   logic               rsp_req_ff, rsp_req_in;
   logic [LEVEL_W-1:0] rsp_val_ff, rsp_val_in;

   logic req_xfer;
   logic csr_xfer;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_xfer  = req_valid & req_ready;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid;

   always_comb begin
      logic [7:0]         fr_cmd;
      logic               fr_ok;
      logic               exec_en;
      logic [7:0]         exec_code;
      logic               key_hit;
      logic [2:0]         key_sel;
      logic [7:0]         key_byte;
      logic [DUTY_W-1:0]  target;
      logic [KEY_W:0]     keys_ext;

      bright_in    = bright_ff;
      on_in        = on_ff;
      last_cmd_in  = last_cmd_ff;
      rep_cnt_in   = rep_cnt_ff;
      idle_cnt_in  = idle_cnt_ff;
      blink_cnt_in = blink_cnt_ff;
      save_cnt_in  = save_cnt_ff;
      stored_in    = stored_ff;
      rsp_req_in   = 1'b0;
      rsp_val_in   = '0;
      exec_en      = 1'b0;
      exec_code    = last_cmd_ff;
      key_hit      = 1'b0;
      key_sel      = '0;
      keys_ext     = {1'b0, key_codes_ff};

      fr_cmd = req_frame_bits[15:8];
      fr_ok  = (req_frame_bits[31:24] == dev_addr_ff) && (fr_cmd == ~req_frame_bits[7:0]);

      if (req_func == FUNC_FRAME) begin
         blink_cnt_in = '0;
         rep_cnt_in   = '0;
         if (fr_ok) begin
            last_cmd_in = fr_cmd;
            exec_en     = 1'b1;
            exec_code   = fr_cmd;
            idle_cnt_in = '0;
         end
      end else if (req_func == FUNC_REPEAT) begin
         blink_cnt_in = '0;
         idle_cnt_in  = '0;
         if (rep_cnt_ff >= rep_delay_ff) begin
            exec_en = 1'b1;
         end else begin
            rep_cnt_in = rep_cnt_ff + 1'b1;
         end
      end

      // first matching slot wins, so scan from the top down
      for (int k = KEYS - 1; k >= 0; k--) begin
         key_byte = keys_ext[8*k +: 8];
         if (key_byte == exec_code) begin
            key_hit = 1'b1;
            key_sel = 3'(k);
         end
      end

      if (exec_en) begin
         on_in       = 1'b1;
         save_cnt_in = '0;
         if (key_hit) begin
            if (key_sel == KEY_UP) begin
               if (bright_ff < TOP_LEVEL) bright_in = bright_ff + 1'b1;
            end else if (key_sel == KEY_DOWN) begin
               if (bright_ff > BOT_LEVEL) bright_in = bright_ff - 1'b1;
            end else if (key_sel == KEY_OFF) begin
               on_in = 1'b0;
            end else if (key_sel[2]) begin
               bright_in = preset_level(key_sel[1:0]);
            end
         end
      end

      rsp_lit_in = blink_cnt_in < blink_len_ff;
      if (rsp_lit_in) blink_cnt_in = blink_cnt_in + 1'b1;

      if (idle_cnt_in > rep_timeout_ff) last_cmd_in = dev_addr_ff;
      if (idle_cnt_in != CNT_MAX) idle_cnt_in = idle_cnt_in + 1'b1;

      if (save_cnt_in <= save_delay_ff && save_cnt_in != CNT_MAX)
         save_cnt_in = save_cnt_in + 1'b1;
      if (save_cnt_in == save_delay_ff && save_en_ff && bright_in != stored_ff) begin
         rsp_req_in = 1'b1;
         rsp_val_in = bright_in;
         stored_in  = bright_in;
      end

      target = on_in ? {gamma_value(clamp_level(bright_in)), 1'b0}
                     : {gamma_value('0), 1'b0};
      if (target > duty_ff)      duty_in = duty_ff + 1'b1;
      else if (target < duty_ff) duty_in = duty_ff - 1'b1;
      else                       duty_in = duty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= '0;
         key_codes_ff   <= '0;
         rep_delay_ff   <= '0;
         blink_len_ff   <= '0;
         rep_timeout_ff <= '0;
         save_delay_ff  <= '0;
         save_en_ff     <= 1'b1;
         bright_ff      <= clamp_level(RESET_BRIGHTNESS);
         stored_ff      <= clamp_level(RESET_BRIGHTNESS);
         on_ff          <= 1'b1;
         duty_ff        <= '0;
         last_cmd_ff    <= '0;
         rep_cnt_ff     <= '0;
         idle_cnt_ff    <= '0;
         blink_cnt_ff   <= '0;
         save_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_xfer) begin
            bright_ff    <= bright_in;
            stored_ff    <= stored_in;
            on_ff        <= on_in;
            duty_ff      <= duty_in;
            last_cmd_ff  <= last_cmd_in;
            rep_cnt_ff   <= rep_cnt_in;
            idle_cnt_ff  <= idle_cnt_in;
            blink_cnt_ff <= blink_cnt_in;
            save_cnt_ff  <= save_cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_xfer) begin
            unique case (csr_index)
               CSR_DEVICE_ADDRESS:     dev_addr_ff    <= csr_data[7:0];
               CSR_KEY_CODES:          key_codes_ff   <= csr_data;
               CSR_REPEAT_DELAY:       rep_delay_ff   <= csr_data[CNT_W-1:0];
               CSR_BLINK_LENGTH:       blink_len_ff   <= csr_data[CNT_W-1:0];
               CSR_REPEAT_TIMEOUT:     rep_timeout_ff <= csr_data[CNT_W-1:0];
               CSR_SAVE_DELAY:         save_delay_ff  <= csr_data[CNT_W-1:0];
               CSR_SAVE_ENABLE:        save_en_ff     <= csr_data[0];
               CSR_INITIAL_BRIGHTNESS: begin
                  bright_ff      <= clamp_level(csr_data[LEVEL_W-1:0]);
                  stored_ff      <= clamp_level(csr_data[LEVEL_W-1:0]);
               end
               default: ;
            endcase
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_duty_ff <= duty_in;
         rsp_lit_ff  <= rsp_lit_in;
         rsp_req_ff  <= rsp_req_in;
         rsp_val_ff  <= rsp_val_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pwm_duty      = rsp_duty_ff;
   assign rsp_indicator_lit = rsp_lit_ff;
   assign rsp_save_request  = rsp_req_ff;
   assign rsp_save_value    = rsp_val_ff;

endmodule

@@ verif/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ird_pkg::*;

   localparam logic [1:0] FUNC_RESERVED     = 2'd3;
   localparam int         FIRST_PRESET_SLOT = 4;
   localparam int         HOLD_CYCLES       = 60;
   localparam int         SETTLE_CYCLES     = 8;
   localparam int         CYCLE_LIMIT       = 300000;

   localparam logic [15:0][7:0] GAMMA_CURVE = {
      8'd255, 8'd192, 8'd146, 8'd111, 8'd84, 8'd64, 8'd49, 8'd37,
      8'd28,  8'd21,  8'd16,  8'd12,  8'd9,  8'd6,  8'd4,  8'd0
   };
   localparam logic [3:0][LEVEL_W-1:0] PRESET_LEVELS = {4'd15, 4'd12, 4'd6, 4'd1};

   typedef struct packed {
      logic [DUTY_W-1:0]  duty;
      logic               lit;
      logic               save_req;
      logic [LEVEL_W-1:0] save_val;
   } dimmer_output_type;

   typedef struct {
      logic [7:0]         addr;
      logic [KEY_W-1:0]   keys;
      logic [CNT_W-1:0]   rep_delay;
      logic [CNT_W-1:0]   blink_len;
      logic [CNT_W-1:0]   rep_timeout;
      logic [CNT_W-1:0]   save_delay;
      logic               save_en;
      logic [LEVEL_W-1:0] init_level;
   } dimmer_regs_type;

   logic clock;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_func = FUNC_TICK;
   logic [31:0]           req_frame_bits = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DUTY_W-1:0]     rsp_pwm_duty;
   logic                  rsp_indicator_lit;
   logic                  rsp_save_request;
   logic [LEVEL_W-1:0]    rsp_save_value;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_DEVICE_ADDRESS;
   logic [KEY_W-1:0]      csr_data = '0;

   ir_remote_dimmer_controller uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_frame_bits    (req_frame_bits),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pwm_duty      (rsp_pwm_duty),
      .rsp_indicator_lit (rsp_indicator_lit),
      .rsp_save_request  (rsp_save_request),
      .rsp_save_value    (rsp_save_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // shadow registers
   logic [7:0]         cfg_addr;
   logic [KEY_W-1:0]   cfg_keys;
   logic [CNT_W-1:0]   cfg_rep_delay, cfg_blink_len, cfg_rep_timeout, cfg_save_delay;
   logic               cfg_save_en;
   logic [LEVEL_W-1:0] cfg_init_level;

   // dimmer state as the block should hold it
   logic [LEVEL_W-1:0] level, stored_level;
   logic               light_on;
   logic [DUTY_W-1:0]  duty;
   logic [7:0]         last_code;
   logic [CNT_W-1:0]   repeat_cnt, idle_cnt, blink_cnt, quiet_cnt;

   dimmer_output_type pending_outputs[$];
   dimmer_output_type want;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int mismatches    = 0;
   int ticks_sent    = 0;
   int outputs_checked = 0;
   int reg_settings  = 0;
   int cycle_count   = 0;

   function automatic void reset_model();
      cfg_addr        = '0;
      cfg_keys        = '0;
      cfg_rep_delay   = '0;
      cfg_blink_len   = '0;
      cfg_rep_timeout = '0;
      cfg_save_delay  = '0;
      cfg_save_en     = 1'b1;
      cfg_init_level  = RESET_BRIGHTNESS;
      level           = RESET_BRIGHTNESS;
      stored_level    = RESET_BRIGHTNESS;
      light_on        = 1'b1;
      duty            = '0;
      last_code       = '0;
      repeat_cnt      = '0;
      idle_cnt        = '0;
      blink_cnt       = '0;
      quiet_cnt       = '0;
   endfunction

   function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] keys, input int slot);
      return 8'({1'b0, keys} >> (8 * slot));
   endfunction

   function automatic logic [7:0] key_code_of(input int slot);
      return key_byte(cfg_keys, slot);
   endfunction

   // first matching slot wins; unmatched codes still wake the output
   function automatic void apply_key(input logic [7:0] code);
      int slot;
      slot      = -1;
      light_on  = 1'b1;
      quiet_cnt = '0;
      for (int k = 0; k < KEYS; k++)
         if (slot < 0 && key_code_of(k) == code) slot = k;
      if (slot == int'(KEY_UP)) begin
         if (level < TOP_LEVEL) level = level + 1'b1;
      end else if (slot == int'(KEY_DOWN)) begin
         if (level > BOT_LEVEL) level = level - 1'b1;
      end else if (slot == int'(KEY_OFF)) begin
         light_on = 1'b0;
      end else if (slot >= FIRST_PRESET_SLOT) begin
         level = PRESET_LEVELS[slot - FIRST_PRESET_SLOT];
      end
   endfunction

   function automatic dimmer_output_type dimmer_tick(input logic [1:0] func,
                                                     input logic [31:0] frame);
      dimmer_output_type r;
      logic [DUTY_W-1:0] goal;
      r = '0;
      if (func == FUNC_FRAME) begin
         blink_cnt = '0;
         if (frame[31:24] == cfg_addr && frame[15:8] == ~frame[7:0]) begin
            last_code = frame[15:8];
            apply_key(frame[15:8]);
            idle_cnt = '0;
         end
         repeat_cnt = '0;
      end else if (func == FUNC_REPEAT) begin
         blink_cnt = '0;
         idle_cnt  = '0;
         if (repeat_cnt >= cfg_rep_delay) apply_key(last_code);
         else repeat_cnt = repeat_cnt + 1'b1;
      end
      r.lit = (blink_cnt < cfg_blink_len);
      if (r.lit) blink_cnt = blink_cnt + 1'b1;
      if (idle_cnt > cfg_rep_timeout) last_code = cfg_addr;
      if (idle_cnt != CNT_MAX) idle_cnt = idle_cnt + 1'b1;
      if (quiet_cnt <= cfg_save_delay && quiet_cnt != CNT_MAX) quiet_cnt = quiet_cnt + 1'b1;
      if (quiet_cnt == cfg_save_delay && cfg_save_en && level != stored_level) begin
         r.save_req   = 1'b1;
         r.save_val   = level;
         stored_level = level;
      end
      goal = light_on ? {GAMMA_CURVE[level], 1'b0} : '0;
      if (goal > duty) duty = duty + 1'b1;
      else if (goal < duty) duty = duty - 1'b1;
      r.duty = duty;
      return r;
   endfunction

   function automatic void check_field(input string what, input logic [DUTY_W-1:0] exp_val,
                                       input logic [DUTY_W-1:0] act_val);
      if (exp_val !== act_val) begin
         mismatches++;
         $display("%0t: %s expected %0d, actual %0d", $time, what, exp_val, act_val);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            mismatches++;
            $display("%0t: output transfer with nothing expected, actual duty %0d",
                     $time, rsp_pwm_duty);
         end else begin
            want = pending_outputs.pop_front();
            check_field("pwm_duty", want.duty, rsp_pwm_duty);
            check_field("indicator_lit", DUTY_W'(want.lit), DUTY_W'(rsp_indicator_lit));
            check_field("save_request", DUTY_W'(want.save_req), DUTY_W'(rsp_save_request));
            check_field("save_value", DUTY_W'(want.save_val), DUTY_W'(rsp_save_value));
            outputs_checked++;
         end
      end
   end

   // output side: random stalls, or a long hold counted here when asked for
   always begin
      @(posedge clock);
      if (holds_served != hold_requests) begin
         holds_served++;
         rsp_ready <= 1'b0;
         for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles, %0d outputs outstanding",
                  $time, CYCLE_LIMIT, pending_outputs.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   task automatic send_tick(input logic [1:0] func, input logic [31:0] frame);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_frame_bits <= frame;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_outputs.push_back(dimmer_tick(func, frame));
      ticks_sent++;
   endtask

   task automatic drain_outputs();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   // unused upper data bits carry noise
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [KEY_W-1:0] value,
                            input int width);
      logic [KEY_W-1:0] data;
      data = (KEY_W'({$urandom, $urandom}) << width) | value;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_DEVICE_ADDRESS:     cfg_addr        = data[7:0];
         CSR_KEY_CODES:          cfg_keys        = data;
         CSR_REPEAT_DELAY:       cfg_rep_delay   = data[7:0];
         CSR_BLINK_LENGTH:       cfg_blink_len   = data[7:0];
         CSR_REPEAT_TIMEOUT:     cfg_rep_timeout = data[7:0];
         CSR_SAVE_DELAY:         cfg_save_delay  = data[7:0];
         CSR_SAVE_ENABLE:        cfg_save_en     = data[0];
         CSR_INITIAL_BRIGHTNESS: begin
            cfg_init_level = data[LEVEL_W-1:0];
            level          = data[LEVEL_W-1:0];
            stored_level   = data[LEVEL_W-1:0];
         end
         default: ;
      endcase
   endtask

   task automatic program_regs(input dimmer_regs_type s);
      write_reg(CSR_DEVICE_ADDRESS, KEY_W'(s.addr), 8);
      write_reg(CSR_KEY_CODES, s.keys, KEY_W);
      write_reg(CSR_REPEAT_DELAY, KEY_W'(s.rep_delay), CNT_W);
      write_reg(CSR_BLINK_LENGTH, KEY_W'(s.blink_len), CNT_W);
      write_reg(CSR_REPEAT_TIMEOUT, KEY_W'(s.rep_timeout), CNT_W);
      write_reg(CSR_SAVE_DELAY, KEY_W'(s.save_delay), CNT_W);
      write_reg(CSR_SAVE_ENABLE, KEY_W'(s.save_en), 1);
      write_reg(CSR_INITIAL_BRIGHTNESS, KEY_W'(s.init_level), LEVEL_W);
      csr_valid <= 1'b0;
      reg_settings++;
   endtask

   function automatic dimmer_regs_type random_regs();
      dimmer_regs_type r;
      r.keys        = KEY_W'({$urandom, $urandom});
      r.addr        = 8'($urandom);
      r.rep_delay   = CNT_W'($urandom_range(0, 6));
      r.blink_len   = CNT_W'($urandom_range(0, 10));
      r.rep_timeout = CNT_W'($urandom_range(0, 20));
      r.save_delay  = CNT_W'($urandom_range(0, 12));
      r.save_en     = ($urandom_range(3) != 0);
      r.init_level  = LEVEL_W'($urandom_range(15));
      // address doubling as a key code makes forgotten-command repeats do something
      if ($urandom_range(3) == 0) r.addr = key_byte(r.keys, $urandom_range(KEYS - 1));
      return r;
   endfunction

   function automatic logic [31:0] good_frame(input logic [7:0] code);
      return {cfg_addr, 8'($urandom), code, ~code};
   endfunction

   task automatic run_random_traffic(input int n_ticks);
      int sent, kind, burst;
      logic [7:0] code;
      sent = 0;
      while (sent < n_ticks) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            if ($urandom_range(4) != 0) code = key_code_of($urandom_range(KEYS - 1));
            else code = 8'($urandom);
            send_tick(FUNC_FRAME, good_frame(code));
            sent++;
         end else if (kind < 65) begin
            burst = $urandom_range(1, 6);
            repeat (burst) begin
               send_tick(FUNC_REPEAT, $urandom);
               sent++;
            end
         end else if (kind < 85) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
               send_tick(($urandom_range(3) == 0) ? FUNC_RESERVED : FUNC_TICK, $urandom);
               sent++;
            end
         end else begin
            // broken frames: pure noise or a good one with a bit flipped
            if ($urandom_range(1)) send_tick(FUNC_FRAME, $urandom);
            else send_tick(FUNC_FRAME, good_frame(8'($urandom)) ^ (32'd1 << $urandom_range(31)));
            sent++;
         end
      end
   endtask

   task automatic test_reset_state();
      send_tick(FUNC_TICK, 32'h0000_0000);
      send_tick(FUNC_FRAME, 32'h0000_00FF);
      send_tick(FUNC_REPEAT, 32'hFFFF_FFFF);
      send_tick(FUNC_FRAME, 32'hFFFF_FFFF);
      send_tick(FUNC_FRAME, 32'h0000_0000);
      send_tick(FUNC_RESERVED, 32'hFFFF_FFFF);
      drain_outputs();
   endtask

   task automatic test_key_actions();
      dimmer_regs_type r;
      r.addr        = 8'hA5;
      r.keys        = {7'h23, 8'h22, 8'h21, 8'h20, 8'h13, 8'h12, 8'h11, 8'h10};
      r.rep_delay   = 8'd2;
      r.blink_len   = 8'd3;
      r.rep_timeout = 8'd4;
      r.save_delay  = 8'd3;
      r.save_en     = 1'b1;
      r.init_level  = 4'd0;
      program_regs(r);
      send_tick(FUNC_FRAME, good_frame(key_code_of(KEY_DOWN)));   // already at the bottom
      send_tick(FUNC_FRAME, good_frame(key_code_of(KEY_UP)));
      repeat (3) send_tick(FUNC_REPEAT, $urandom);                // only the third acts
      for (int p = 0; p < 4; p++)
         send_tick(FUNC_FRAME, good_frame(key_code_of(FIRST_PRESET_SLOT + p)));
      send_tick(FUNC_FRAME, good_frame(key_code_of(KEY_UP)));     // already at the top
      send_tick(FUNC_FRAME, good_frame(key_code_of(KEY_OFF)));
      send_tick(FUNC_FRAME, good_frame(key_code_of(KEY_ON)));
      send_tick(FUNC_FRAME, good_frame(8'h55));                   // matches no key
      send_tick(FUNC_FRAME, {~cfg_addr, 8'h00, 8'h10, 8'hEF});
      send_tick(FUNC_FRAME, {cfg_addr, 8'h00, 8'h10, 8'h10});
      repeat (6) send_tick(FUNC_TICK, 32'h0);
      send_tick(FUNC_REPEAT, 32'h0);                              // command forgotten by now
      drain_outputs();
   endtask

   task automatic test_extreme_settings();
      dimmer_regs_type r;
      r.addr        = '0;
      r.keys        = '0;
      r.rep_delay   = '0;
      r.blink_len   = '0;
      r.rep_timeout = '0;
      r.save_delay  = '0;
      r.save_en     = 1'b0;
      r.init_level  = '0;
      program_regs(r);
      run_random_traffic(70);
      drain_outputs();
      r.addr        = '1;
      r.keys        = '1;
      r.rep_delay   = '1;
      r.blink_len   = '1;
      r.rep_timeout = '1;
      r.save_delay  = '1;
      r.save_en     = 1'b1;
      r.init_level  = '1;
      program_regs(r);
      run_random_traffic(70);
      drain_outputs();
   endtask

   task automatic test_random_settings(input int phases);
      repeat (phases) begin
         program_regs(random_regs());
         run_random_traffic(160);
         drain_outputs();
      end
   endtask

   task automatic test_duplicate_keys();
      dimmer_regs_type r;
      logic [63:0] k;
      r = random_regs();
      k = {1'b0, r.keys};
      k[15:8]  = k[7:0];    // down shares the up code
      k[47:40] = k[23:16];  // second preset shares the off code
      k[39:32] = k[31:24];  // first preset shares the on code
      r.keys = k[KEY_W-1:0];
      program_regs(r);
      run_random_traffic(100);
      drain_outputs();
   endtask

   task automatic test_output_stall();
      program_regs(random_regs());
      hold_requests++;
      run_random_traffic(40);
      drain_outputs();
   endtask

   initial begin
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      set_idle(37, 47);
      test_reset_state();
      test_key_actions();
      test_extreme_settings();

      set_idle(47, 37);
      test_random_settings(3);
      test_duplicate_keys();

      set_idle(0, 0);
      test_output_stall();
      test_random_settings(1);

      drain_outputs();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_outputs.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected outputs never arrived", $time, pending_outputs.size());
      end
      $display("%0d ticks sent and %0d outputs checked across %0d register settings,",
               ticks_sent, outputs_checked, reg_settings);
      $display("covering extreme settings, duplicate key codes and a long output stall");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
